// ----- src/ptt_pkg.sv -----
// Package for the periodic timer table: sizes, codes, controller state and the
// command/status structs between controller and datapath. No dependencies.
package ptt_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TIME_WIDTH = 48;
    localparam int ID_W       = 4;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef logic [TIME_WIDTH-1:0] ptt_time_t;
    typedef logic [IDX_W-1:0]      ptt_idx_t;

    localparam ptt_time_t TIME_MAX = '1;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_CANCEL = 2'd2,
        FUNC_QUERY  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_NONE  = 2'd1,
        KIND_DELAY = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_PREP,
        ST_SET_WRITE,
        ST_CANCEL,
        ST_SCAN,
        ST_FIRE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic set_prep;
        logic set_write;
        logic cancel;
        logic scan_step;
        logic fire;
        logic emit;
    } ptt_cmd_t;

    typedef struct packed {
        logic  in_valid;
        func_t in_func;
        func_t func;
        logic  scan_end;
        logic  found;
        logic  last_fire;
        logic  out_free;
    } ptt_stat_t;

    // Add with saturation at the all-ones time value.
    function automatic ptt_time_t sat_add(input ptt_time_t a, input ptt_time_t b);
        logic [TIME_WIDTH:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TIME_WIDTH] ? TIME_MAX : sum[TIME_WIDTH-1:0];
    endfunction

endpackage

// ----- src/ptt_if.sv -----
// Valid/ready channel interfaces for the timer table: request items and results.
// Depends on ptt_pkg for the id and time widths.
interface ptt_item_if;
    import ptt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            func;
    logic [ID_W-1:0]       timer_idx;
    logic [TIME_WIDTH-1:0] now_time;
    logic [TIME_WIDTH-1:0] real_time;
    logic                  realtime_clock;
    logic                  abs_time;
    logic [TIME_WIDTH-1:0] set_value;
    logic [TIME_WIDTH-1:0] set_interval;

    modport source (
        output valid, func, timer_idx, now_time, real_time, realtime_clock,
               abs_time, set_value, set_interval,
        input  ready
    );
    modport sink (
        input  valid, func, timer_idx, now_time, real_time, realtime_clock,
               abs_time, set_value, set_interval,
        output ready
    );
endinterface

interface ptt_result_if;
    import ptt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [1:0]            kind;
    logic [ID_W-1:0]       fired_timer;
    logic [TIME_WIDTH-1:0] next_delay;
    logic                  last;

    modport source (
        output valid, kind, fired_timer, next_delay, last,
        input  ready
    );
    modport sink (
        input  valid, kind, fired_timer, next_delay, last,
        output ready
    );
endinterface

// ----- src/periodic_timer_table.sv -----
// Periodic timer table: top level joining controller and datapath.
// Depends on ptt_pkg, ptt_if, ptt_ctrl and ptt_datapath.
//
// Usage: requests arrive on the item channel (valid/ready), results leave on
// the result channel (valid/ready) through an output register. One request is
// in work at a time; item.ready is high only while the block is idle.
//   set:    prepare and write steps, no result transaction.
//   cancel: a cancel step, no result transaction.
//   query:  a serial scan over the table, then a load of the result register
//           (one transaction, last set).
//   tick:   each fired timer costs one full scan, a timer update and a load of
//           the result. A tick that fires nothing gives one transaction after
//           a full scan.
// The scan reads one table entry per cycle.
// A stalled receiver holds the result register; the controller waits at the
// result load until it drains.
// Reset disarms all timers and empties the result register.
module periodic_timer_table (
    input  logic         clk,
    input  logic         rst_n,
    ptt_item_if.sink     item,
    ptt_result_if.source result
);
    import ptt_pkg::*;

    ptt_cmd_t  cmd;
    ptt_stat_t stat;

    ptt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    ptt_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .stat   (stat),
        .item   (item),
        .result (result)
    );

endmodule

// ----- src/ptt_datapath.sv -----
// Datapath of the timer table: timer storage, the serial min-expiry scan,
// expiry arithmetic and the result register. Depends on ptt_pkg and ptt_if.
module ptt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  ptt_pkg::ptt_cmd_t   cmd,
    output ptt_pkg::ptt_stat_t  stat,
    ptt_item_if.sink            item,
    ptt_result_if.source        result
);
    import ptt_pkg::*;

    // captured request
    func_t           func_reg;
    logic [ID_W-1:0] id_reg;
    ptt_time_t       now_reg;
    ptt_time_t       real_reg;
    logic            rt_reg;
    logic            abs_reg;
    ptt_time_t       value_reg;
    ptt_time_t       interval_reg;

    // timer table
    ptt_time_t             expiry_reg [NUM_TIMERS];
    ptt_time_t             reload_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] armed_reg;
    logic [NUM_TIMERS-1:0] due_reg;

    // scan state
    ptt_idx_t  idx_reg;
    logic      first_reg;
    logic      found_reg;
    ptt_time_t best_reg;
    ptt_idx_t  pick_reg;
    logic      last_reg;

    // set arithmetic
    ptt_time_t offset_reg;
    logic      direct_reg;
    logic      sub_reg;

    // result register
    logic            out_valid_reg;
    kind_t           kind_reg;
    logic [ID_W-1:0] fired_reg;
    ptt_time_t       delay_reg;
    logic            olast_reg;

    logic                  accept;
    logic                  id_ok;
    ptt_idx_t              id_idx;
    ptt_time_t             cur_exp;
    logic                  cand;
    logic                  found_eff;
    logic                  take;
    logic                  scan_end;
    logic [TIME_WIDTH:0]   diff;
    ptt_time_t             set_exp;
    ptt_time_t             pick_reload;
    logic [NUM_TIMERS-1:0] due_left;
    kind_t                 kind_next;
    ptt_time_t             delay_next;

    assign accept     = item.valid && cmd.in_ready;
    assign item.ready = cmd.in_ready;

    assign id_ok  = 32'(id_reg) < NUM_TIMERS;
    assign id_idx = IDX_W'(id_reg);

    assign cur_exp   = expiry_reg[idx_reg];
    assign found_eff = found_reg && (idx_reg != '0);
    assign scan_end  = idx_reg == IDX_W'(NUM_TIMERS - 1);

    always_comb
    begin
        if (func_reg == FUNC_QUERY)
            cand = armed_reg[idx_reg];
        else if (first_reg)
            cand = armed_reg[idx_reg] && (cur_exp <= now_reg);
        else
            cand = due_reg[idx_reg];
    end

    // strict compare keeps the lowest index on equal expiry
    assign take = cand && (!found_eff || (cur_exp < best_reg));

    assign diff = {1'b0, value_reg} - {1'b0, real_reg};

    always_comb
    begin
        if (direct_reg)
            set_exp = value_reg;
        else if (sub_reg)
            set_exp = (now_reg > offset_reg) ? (now_reg - offset_reg) : '0;
        else
            set_exp = sat_add(now_reg, offset_reg);
    end

    assign pick_reload = reload_reg[pick_reg];

    always_comb
    begin
        due_left           = due_reg;
        due_left[pick_reg] = 1'b0;
    end

    always_comb
    begin
        if (func_reg == FUNC_QUERY)
            kind_next = KIND_DELAY;
        else if (found_reg)
            kind_next = KIND_FIRED;
        else
            kind_next = KIND_NONE;
        if (func_reg != FUNC_QUERY)
            delay_next = '0;
        else if (!found_reg)
            delay_next = TIME_MAX;
        else
            delay_next = (best_reg > now_reg) ? (best_reg - now_reg) : '0;
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func_t'(item.func);
            id_reg       <= item.timer_idx;
            now_reg      <= item.now_time;
            real_reg     <= item.real_time;
            rt_reg       <= item.realtime_clock;
            abs_reg      <= item.abs_time;
            value_reg    <= item.set_value;
            interval_reg <= item.set_interval;
        end
    end

    // table payload
    always_ff @(posedge clk)
    begin
        if (cmd.set_prep && id_ok)
            reload_reg[id_idx] <= interval_reg;
        if (cmd.set_write && id_ok && (value_reg != '0))
            expiry_reg[id_idx] <= set_exp;
        if (cmd.fire && (pick_reload != '0))
            expiry_reg[pick_reg] <= sat_add(now_reg, pick_reload);
    end

    // set arithmetic and scan payload
    always_ff @(posedge clk)
    begin
        if (cmd.set_prep)
        begin
            direct_reg <= abs_reg && !rt_reg;
            sub_reg    <= abs_reg && rt_reg && diff[TIME_WIDTH];
            if (!abs_reg)
                offset_reg <= value_reg;
            else if (diff[TIME_WIDTH])
                offset_reg <= real_reg - value_reg;
            else
                offset_reg <= diff[TIME_WIDTH-1:0];
        end
        if (cmd.scan_step && take)
        begin
            best_reg <= cur_exp;
            pick_reg <= idx_reg;
        end
        if (cmd.fire)
            last_reg <= (due_left == '0);
        if (cmd.emit)
        begin
            kind_reg  <= kind_next;
            fired_reg <= (kind_next == KIND_FIRED) ? ID_W'(pick_reg) : '0;
            delay_reg <= delay_next;
            olast_reg <= (kind_next == KIND_FIRED) ? last_reg : 1'b1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= '0;
            due_reg       <= '0;
            idx_reg       <= '0;
            first_reg     <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                first_reg <= 1'b1;
            if (cmd.set_prep && id_ok)
                armed_reg[id_idx] <= 1'b0;
            if (cmd.set_write && id_ok && (value_reg != '0))
                armed_reg[id_idx] <= 1'b1;
            if (cmd.cancel && id_ok)
                armed_reg[id_idx] <= 1'b0;
            if (cmd.scan_step)
            begin
                idx_reg   <= scan_end ? '0 : idx_reg + 1'b1;
                found_reg <= found_eff || take;
                if (first_reg && (func_reg == FUNC_TICK))
                    due_reg[idx_reg] <= cand;
            end
            if (cmd.fire)
            begin
                first_reg           <= 1'b0;
                due_reg[pick_reg]   <= 1'b0;
                armed_reg[pick_reg] <= pick_reload != '0;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.kind        = kind_reg;
    assign result.fired_timer = fired_reg;
    assign result.next_delay  = delay_reg;
    assign result.last        = olast_reg;

    always_comb
    begin
        stat.in_valid  = item.valid;
        stat.in_func   = func_t'(item.func);
        stat.func      = func_reg;
        stat.scan_end  = scan_end;
        stat.found     = found_reg;
        stat.last_fire = last_reg;
        stat.out_free  = !out_valid_reg || result.ready;
    end

endmodule

// ----- src/ptt_ctrl.sv -----
// Controller of the timer table: sequences set, cancel, scan, fire and result
// transactions. Depends on ptt_pkg.
module ptt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  ptt_pkg::ptt_stat_t stat,
    output ptt_pkg::ptt_cmd_t  cmd
);
    import ptt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (stat.in_valid)
                begin
                    if (stat.in_func inside {FUNC_TICK, FUNC_QUERY})
                        state_next = ST_SCAN;
                    else if (stat.in_func == FUNC_SET)
                        state_next = ST_SET_PREP;
                    else
                        state_next = ST_CANCEL;
                end
            end
            ST_SET_PREP:
            begin
                cmd.set_prep = 1'b1;
                state_next   = ST_SET_WRITE;
            end
            ST_SET_WRITE:
            begin
                cmd.set_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_CANCEL:
            begin
                cmd.cancel = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_end)
                begin
                    // the found flag is final only after the last step lands
                    state_next = ST_FIRE;
                    if (stat.func == FUNC_QUERY)
                        state_next = ST_EMIT;
                end
            end
            ST_FIRE:
            begin
                if (stat.found)
                    cmd.fire = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if ((stat.func == FUNC_TICK) && stat.found && !stat.last_fire)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- verif/periodic_timer_table_tb.sv -----
`timescale 1ns / 100ps
// Testbench for periodic_timer_table: directed table, then random timer traffic.
// Checks each result against an in-bench timer table predictor or its typed row.
// Depends on ptt_pkg, ptt_if and the periodic_timer_table RTL.
module periodic_timer_table_tb;
    import ptt_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int QUIET_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 84;
    localparam int BURST_ITEMS  = 24;
    localparam int DRAIN_CYCLES = NUM_TIMERS * (NUM_TIMERS + 2);
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        func_t     fn;
        logic [3:0] tid;
        ptt_time_t now_us;
        ptt_time_t rt_now;
        logic      rt_clk;
        logic      is_abs;
        ptt_time_t val;
        ptt_time_t ivl;
    } req_t;

    typedef struct {
        kind_t      kind;
        logic [3:0] tid;
        ptt_time_t  delay;
        logic       last;
    } res_t;

    typedef struct {
        req_t      rq;
        bit        typed;
        kind_t     ekind;
        ptt_time_t edelay;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ptt_item_if   item_ch ();
    ptt_result_if res_ch ();

    periodic_timer_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    // Predicted timer table
    ptt_time_t expiry_q[NUM_TIMERS];
    bit        armed_q[NUM_TIMERS];
    ptt_time_t period_q[NUM_TIMERS];

    res_t      step_out[$];
    res_t      expected_q[$];
    dir_row_t  dir_tab[$];

    int        err_count;
    int        src_idle_pct;
    int        snk_stall_pct;
    bit        hold_req;
    ptt_time_t cur_now;

    always #HALF_PERIOD clk = ~clk;

    function automatic ptt_time_t add_sat(input ptt_time_t a, input ptt_time_t b);
        return (b > (TIME_MAX - a)) ? TIME_MAX : a + b;
    endfunction

    function automatic ptt_time_t rand48();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[TIME_WIDTH-1:0];
    endfunction

    // Apply one request to the predicted table; results land in step_out.
    function automatic void timers_step(input req_t r);
        bit        due[NUM_TIMERS];
        bit        any;
        ptt_time_t best;
        ptt_time_t ex;
        ptt_time_t deficit;
        int        n_due;
        int        pick;
        res_t      o;
        step_out.delete();
        case (r.fn)
            FUNC_SET:
            begin
                armed_q[r.tid]  = 1'b0;
                period_q[r.tid] = r.ivl;
                if (r.val != '0)
                begin
                    if (!r.is_abs)
                        ex = add_sat(r.now_us, r.val);
                    else if (!r.rt_clk)
                        ex = r.val;
                    else if (r.val >= r.rt_now)
                        ex = add_sat(r.now_us, r.val - r.rt_now);
                    else
                    begin
                        deficit = r.rt_now - r.val;
                        ex = (r.now_us > deficit) ? r.now_us - deficit : '0;
                    end
                    expiry_q[r.tid] = ex;
                    armed_q[r.tid]  = 1'b1;
                end
            end
            FUNC_CANCEL:
                armed_q[r.tid] = 1'b0;
            FUNC_QUERY:
            begin
                any  = 1'b0;
                best = TIME_MAX;
                for (int i = 0; i < NUM_TIMERS; i++)
                    if (armed_q[i] && (!any || expiry_q[i] < best))
                    begin
                        best = expiry_q[i];
                        any  = 1'b1;
                    end
                o.kind  = KIND_DELAY;
                o.tid   = '0;
                o.delay = !any ? TIME_MAX : ((best > r.now_us) ? best - r.now_us : '0);
                o.last  = 1'b1;
                step_out.push_back(o);
            end
            default:
            begin
                n_due = 0;
                for (int i = 0; i < NUM_TIMERS; i++)
                begin
                    due[i] = armed_q[i] && (expiry_q[i] <= r.now_us);
                    if (due[i])
                        n_due++;
                end
                if (n_due == 0)
                begin
                    o.kind  = KIND_NONE;
                    o.tid   = '0;
                    o.delay = '0;
                    o.last  = 1'b1;
                    step_out.push_back(o);
                end
                for (int k = 0; k < n_due; k++)
                begin
                    pick = -1;
                    for (int i = 0; i < NUM_TIMERS; i++)
                        if (due[i] && (pick < 0 || expiry_q[i] < expiry_q[pick]))
                            pick = i;
                    due[pick]     = 1'b0;
                    armed_q[pick] = 1'b0;
                    // reload from now, never from the old expiry
                    if (period_q[pick] != '0)
                    begin
                        expiry_q[pick] = add_sat(r.now_us, period_q[pick]);
                        armed_q[pick]  = 1'b1;
                    end
                    o.kind  = KIND_FIRED;
                    o.tid   = pick[3:0];
                    o.delay = '0;
                    o.last  = (k == n_due - 1);
                    step_out.push_back(o);
                end
            end
        endcase
    endfunction

    function automatic dir_row_t row(input func_t f, input int id, input ptt_time_t now,
                                     input ptt_time_t rt, input bit rc, input bit ab,
                                     input ptt_time_t v, input ptt_time_t iv,
                                     input bit ty, input kind_t k, input ptt_time_t d);
        dir_row_t x;
        x.rq.fn     = f;
        x.rq.tid    = id[3:0];
        x.rq.now_us = now;
        x.rq.rt_now = rt;
        x.rq.rt_clk = rc;
        x.rq.is_abs = ab;
        x.rq.val    = v;
        x.rq.ivl    = iv;
        x.typed     = ty;
        x.ekind     = k;
        x.edelay    = d;
        return x;
    endfunction

    // Mostly coherent traffic around a drifting time base, some pure noise.
    function automatic req_t gen_item();
        req_t r;
        int   p;
        r.tid    = 4'($urandom_range(15));
        r.rt_clk = 1'($urandom_range(1));
        r.is_abs = 1'($urandom_range(1));
        r.rt_now = rand48();
        r.val    = rand48();
        r.ivl    = rand48();
        p = $urandom_range(99);
        if (p < 10)
        begin
            r.fn     = func_t'($urandom_range(3));
            r.now_us = rand48();
            return r;
        end
        p = $urandom_range(99);
        if (p < 2)
            cur_now = TIME_MAX - ptt_time_t'($urandom_range(300));
        else if (p < 4)
            cur_now = ptt_time_t'($urandom_range(50));
        else if (p < 6)
            cur_now = rand48();
        else
            cur_now = add_sat(cur_now, ptt_time_t'($urandom_range(40)));
        r.now_us = cur_now;
        p = $urandom_range(99);
        if (p < 35)
        begin
            r.fn = FUNC_SET;
            if (!r.is_abs)
            begin
                if ($urandom_range(19) == 0)
                    r.val = '0;
                else if ($urandom_range(19) == 0)
                    r.val = rand48();
                else
                    r.val = ptt_time_t'($urandom_range(120, 1));
            end
            else if (!r.rt_clk)
                r.val = cur_now + ptt_time_t'($urandom_range(150)) - ptt_time_t'(40);
            else
                r.val = r.rt_now + ptt_time_t'($urandom_range(150)) - ptt_time_t'(40);
            p = $urandom_range(99);
            if (p < 50)
                r.ivl = '0;
            else if (p < 95)
                r.ivl = ptt_time_t'($urandom_range(150, 1));
        end
        else if (p < 70)
            r.fn = FUNC_TICK;
        else if (p < 85)
            r.fn = FUNC_QUERY;
        else
            r.fn = FUNC_CANCEL;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (err_count < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // Offer one transaction; on acceptance record its expected results.
    task automatic drive_item(input req_t r, input bit typed, input res_t typed_res);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid          <= 1'b1;
        item_ch.func           <= r.fn;
        item_ch.timer_idx      <= r.tid;
        item_ch.now_time       <= r.now_us;
        item_ch.real_time      <= r.rt_now;
        item_ch.realtime_clock <= r.rt_clk;
        item_ch.abs_time       <= r.is_abs;
        item_ch.set_value      <= r.val;
        item_ch.set_interval   <= r.ivl;
        do
            @(posedge clk);
        while (!item_ch.ready);
        timers_step(r);
        if (typed)
            expected_q.push_back(typed_res);
        else
            foreach (step_out[i])
                expected_q.push_back(step_out[i]);
        @(negedge clk);
    endtask

    // Result receiver, with a one-off long hold-off on request
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
                res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        res_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_q.size() == 0)
                report_mismatch($sformatf("unexpected result kind=%0d timer=%0d",
                                          res_ch.kind, res_ch.fired_timer));
            else
            begin
                e = expected_q.pop_front();
                if (res_ch.kind !== e.kind || res_ch.fired_timer !== e.tid ||
                    res_ch.next_delay !== e.delay || res_ch.last !== e.last)
                    report_mismatch($sformatf(
                        "got kind=%0d timer=%0d delay=%h last=%b, want %0d %0d %h %b",
                        res_ch.kind, res_ch.fired_timer, res_ch.next_delay, res_ch.last,
                        e.kind, e.tid, e.delay, e.last));
            end
        end
    end

    // Watchdog: cycles in a row with no transaction on either channel
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        res_t blank;
        res_t typed_res;
        int   src_pct[4];
        int   snk_pct[4];
        clk           = 1'b0;
        rst_n         = 1'b0;
        err_count     = 0;
        hold_req      = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        cur_now       = '0;
        quiet_cycles  = 0;
        blank         = '{KIND_FIRED, '0, '0, 1'b0};
        src_pct       = '{0, 78, 0, 33};
        snk_pct       = '{0, 0, 78, 33};

        item_ch.valid          = 1'b0;
        item_ch.func           = FUNC_TICK;
        item_ch.timer_idx      = '0;
        item_ch.now_time       = '0;
        item_ch.real_time      = '0;
        item_ch.realtime_clock = 1'b0;
        item_ch.abs_time       = 1'b0;
        item_ch.set_value      = '0;
        item_ch.set_interval   = '0;

        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            expiry_q[i] = TIME_MAX;
            armed_q[i]  = 1'b0;
            period_q[i] = '0;
        end

        // empty table, saturation, real-time clamps, ties, periodic reload at the top
        dir_tab.push_back(row(FUNC_QUERY,  0, '0, '0, 0, 0, '0, '0, 1, KIND_DELAY, TIME_MAX));
        dir_tab.push_back(row(FUNC_TICK,   0, '0, '0, 0, 0, '0, '0, 1, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_SET,    0, TIME_MAX - 5, '0, 0, 0, 100, '0,
                              0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_SET,    1, 5, 1000, 1, 1, 10, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_SET,    2, 100, '0, 1, 1, TIME_MAX, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_SET,    3, 7, 3, 0, 1, 50, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_SET,    4, 0, '0, 0, 0, '0, 33, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_SET,    5, 0, '0, 0, 0, 10, 7, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_SET,   15, 0, '0, 0, 1, 20, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_SET,    6, 0, '0, 0, 1, 20, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_QUERY,  0, '0, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_TICK,   0, 20, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_CANCEL, 6, 20, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_TICK,   0, TIME_MAX, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_QUERY,  0, TIME_MAX, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_TICK,   0, TIME_MAX, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_CANCEL, 5, TIME_MAX, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_QUERY,  0, 123, '0, 0, 0, '0, '0, 1, KIND_DELAY, TIME_MAX));
        dir_tab.push_back(row(FUNC_TICK,  15, TIME_MAX, TIME_MAX, 1, 1, TIME_MAX, TIME_MAX,
                              1, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_SET,    9, 0, '0, 0, 0, 1, TIME_MAX, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_QUERY,  0, 10, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_TICK,   0, 10, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));
        dir_tab.push_back(row(FUNC_CANCEL, 9, 10, '0, 0, 0, '0, '0, 0, KIND_NONE, '0));

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            typed_res       = blank;
            typed_res.kind  = dir_tab[i].ekind;
            typed_res.delay = dir_tab[i].edelay;
            typed_res.last  = 1'b1;
            drive_item(dir_tab[i].rq, dir_tab[i].typed, typed_res);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct  = src_pct[ph];
            snk_stall_pct = snk_pct[ph];
            for (int n = 0; n < PHASE_ITEMS; n++)
                drive_item(gen_item(), 1'b0, blank);
            if (ph == 0)
            begin
                // hold the receiver off and keep offering until the block backs up
                hold_req = 1'b1;
                for (int n = 0; n < BURST_ITEMS; n++)
                    drive_item(gen_item(), 1'b0, blank);
            end
        end
        item_ch.valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
